[hw/rtl/m3i_pkg.sv]
package m3i_pkg;

  // Number of entries in one 3x3 matrix.
  localparam int N_ENT = 9;

  typedef logic [3:0] ent_idx_t;

  // Cofactor terms: adjugate entry k = m[a] * m[b] - m[c] * m[d],
  // with the matrix flattened row by row.
  localparam ent_idx_t ADJ_TERM [N_ENT][4] = '{
    '{4'd4, 4'd8, 4'd5, 4'd7},
    '{4'd2, 4'd7, 4'd1, 4'd8},
    '{4'd1, 4'd5, 4'd2, 4'd4},
    '{4'd5, 4'd6, 4'd3, 4'd8},
    '{4'd0, 4'd8, 4'd2, 4'd6},
    '{4'd2, 4'd3, 4'd0, 4'd5},
    '{4'd3, 4'd7, 4'd4, 4'd6},
    '{4'd1, 4'd6, 4'd0, 4'd7},
    '{4'd0, 4'd4, 4'd1, 4'd3}
  };

  // Per-item flags that travel from the front end to the divider pipeline.
  typedef struct packed {
    logic             singular;
    logic [N_ENT-1:0] neg;
  } item_flags_t;

  // Magnitude of an adjugate entry.
  function automatic int cmag_width(int w);
    return 2 * w + 1;
  endfunction

  // Magnitude of the determinant.
  function automatic int dmag_width(int w);
    return 3 * w + 3;
  endfunction

  // Rounded dividend: |C| * 2^(2F+1) + |D|.
  function automatic int num_width(int w, int f);
    int a;
    int b;
    a = cmag_width(w) + 2 * f + 1;
    b = dmag_width(w);
    return ((a > b) ? a : b) + 1;
  endfunction

  // Divisor: 2 * |D|.
  function automatic int den_width(int w);
    return dmag_width(w) + 1;
  endfunction

  // Partial remainder of the divider.
  function automatic int rem_width(int w, int f);
    int a;
    int b;
    a = num_width(w, f);
    b = den_width(w) + w;
    return (a > b) ? a : b;
  endfunction

endpackage

[hw/rtl/m3i_if.sv]
// Matrix channel into the block.
interface m3i_in_if #(parameter int W = 32);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] in_r0c0;
  logic signed [W-1:0] in_r0c1;
  logic signed [W-1:0] in_r0c2;
  logic signed [W-1:0] in_r1c0;
  logic signed [W-1:0] in_r1c1;
  logic signed [W-1:0] in_r1c2;
  logic signed [W-1:0] in_r2c0;
  logic signed [W-1:0] in_r2c1;
  logic signed [W-1:0] in_r2c2;

  modport source (
    output valid, in_r0c0, in_r0c1, in_r0c2, in_r1c0, in_r1c1, in_r1c2,
    in_r2c0, in_r2c1, in_r2c2,
    input ready
  );
  modport sink (
    input valid, in_r0c0, in_r0c1, in_r0c2, in_r1c0, in_r1c1, in_r1c2,
    in_r2c0, in_r2c1, in_r2c2,
    output ready
  );
endinterface

// Inverse channel out of the block.
interface m3i_out_if #(parameter int W = 32);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] out_r0c0;
  logic signed [W-1:0] out_r0c1;
  logic signed [W-1:0] out_r0c2;
  logic signed [W-1:0] out_r1c0;
  logic signed [W-1:0] out_r1c1;
  logic signed [W-1:0] out_r1c2;
  logic signed [W-1:0] out_r2c0;
  logic signed [W-1:0] out_r2c1;
  logic signed [W-1:0] out_r2c2;
  logic                singular;
  logic                overflow;

  modport source (
    output valid, out_r0c0, out_r0c1, out_r0c2, out_r1c0, out_r1c1, out_r1c2,
    out_r2c0, out_r2c1, out_r2c2, singular, overflow,
    input ready
  );
  modport sink (
    input valid, out_r0c0, out_r0c1, out_r0c2, out_r1c0, out_r1c1, out_r1c2,
    out_r2c0, out_r2c1, out_r2c2, singular, overflow,
    output ready
  );
endinterface

[hw/rtl/m3i_front.sv]
module m3i_front #(
  parameter int W     = 32,
  parameter int F     = 16,
  parameter int NUM_W = m3i_pkg::num_width(W, F),
  parameter int DEN_W = m3i_pkg::den_width(W)
) (
  input  logic                      clk,
  input  logic                      rst,
  m3i_in_if.sink                    mat,
  output logic                      push,
  input  logic                      q_ready,
  output logic [NUM_W-1:0]          num [m3i_pkg::N_ENT],
  output logic [DEN_W-1:0]          den2,
  output m3i_pkg::item_flags_t      flags
);
  import m3i_pkg::*;

  localparam int PW  = 2 * W;
  localparam int AW  = 2 * W + 1;
  localparam int DW  = 3 * W + 3;
  localparam int CMW = cmag_width(W);
  localparam int DMW = dmag_width(W);

  logic                adv;
  logic [6:1]          vld;
  logic signed [W-1:0] m [N_ENT];

  logic signed [PW-1:0]  prod_a [N_ENT];
  logic signed [PW-1:0]  prod_b [N_ENT];
  logic signed [W-1:0]   row0_s1 [3];
  logic signed [W-1:0]   row0_s2 [3];
  logic signed [AW-1:0]  adj_s2 [N_ENT];
  logic signed [AW-1:0]  adj_s3 [N_ENT];
  logic signed [AW-1:0]  adj_s4 [N_ENT];
  logic signed [AW-1:0]  part_lo [3];
  logic signed [AW-1:0]  part_hi [3];
  logic signed [DW-1:0]  det_s4;
  logic signed [DW-1:0]  det_sum;
  logic [CMW-1:0]        cmag [N_ENT];
  logic [DMW-1:0]        dmag;
  item_flags_t           flags_s5;

  assign m[0] = mat.in_r0c0;
  assign m[1] = mat.in_r0c1;
  assign m[2] = mat.in_r0c2;
  assign m[3] = mat.in_r1c0;
  assign m[4] = mat.in_r1c1;
  assign m[5] = mat.in_r1c2;
  assign m[6] = mat.in_r2c0;
  assign m[7] = mat.in_r2c1;
  assign m[8] = mat.in_r2c2;

  // The whole front pipeline moves unless its last stage is held by a full queue.
  assign adv       = !vld[6] || q_ready;
  assign mat.ready = adv;
  assign push      = vld[6] && q_ready;

  // Valid bits of the six front stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[5:1], mat.valid};
    end
  end

  // Stage 1: the eighteen 2x2 cofactor products.
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < N_ENT; k++) begin
        prod_a[k] <= PW'(m[ADJ_TERM[k][0]]) * PW'(m[ADJ_TERM[k][1]]);
        prod_b[k] <= PW'(m[ADJ_TERM[k][2]]) * PW'(m[ADJ_TERM[k][3]]);
      end
      for (int j = 0; j < 3; j++) begin
        row0_s1[j] <= m[j];
      end
    end
  end

  // Stage 2: adjugate entries.
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < N_ENT; k++) begin
        adj_s2[k] <= AW'(prod_a[k]) - AW'(prod_b[k]);
      end
      row0_s2 <= row0_s1;
    end
  end

  // Stage 3: determinant partial products, adjugate split into low and high halves.
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < 3; j++) begin
        part_lo[j] <= AW'(row0_s2[j]) * AW'($signed({1'b0, adj_s2[3*j][W-1:0]}));
        part_hi[j] <= AW'(row0_s2[j]) * AW'($signed(adj_s2[3*j][AW-1:W]));
      end
      adj_s3 <= adj_s2;
    end
  end

  // Determinant as the sum of the shifted partial products.
  always_comb begin
    det_sum = '0;
    for (int j = 0; j < 3; j++) begin
      det_sum = det_sum + (DW'(part_hi[j]) <<< W) + DW'(part_lo[j]);
    end
  end

  // Stage 4: determinant.
  always_ff @(posedge clk) begin
    if (adv) begin
      det_s4 <= det_sum;
      adj_s4 <= adj_s3;
    end
  end

  // Stage 5: classify the item and take magnitudes and signs.
  always_ff @(posedge clk) begin
    if (adv) begin
      flags_s5.singular <= (det_s4 == '0);
      dmag <= det_s4[DW-1] ? DMW'(-det_s4) : DMW'(det_s4);
      for (int k = 0; k < N_ENT; k++) begin
        flags_s5.neg[k] <= adj_s4[k][AW-1] ^ det_s4[DW-1];
        cmag[k] <= adj_s4[k][AW-1] ? CMW'(-adj_s4[k]) : CMW'(adj_s4[k]);
      end
    end
  end

  // Stage 6: dividend with the rounding half folded in, and the doubled divisor.
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < N_ENT; k++) begin
        num[k] <= (NUM_W'(cmag[k]) << (2 * F + 1)) + NUM_W'(dmag);
      end
      den2  <= DEN_W'(dmag) << 1;
      flags <= flags_s5;
    end
  end

endmodule

[hw/rtl/m3i_queue.sv]
module m3i_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             ready,
  input  logic [WIDTH-1:0] wdata,
  output logic             valid,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] slot [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  assign ready = (count != 2'd2);
  assign valid = (count != 2'd0);
  assign rdata = slot[rd_ptr];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= wdata;
    end
  end

endmodule

[hw/rtl/m3i_back.sv]
module m3i_back #(
  parameter int W     = 32,
  parameter int F     = 16,
  parameter int NUM_W = m3i_pkg::num_width(W, F),
  parameter int DEN_W = m3i_pkg::den_width(W)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      q_valid,
  output logic                      pop,
  input  logic [NUM_W-1:0]          num [m3i_pkg::N_ENT],
  input  logic [DEN_W-1:0]          den2,
  input  m3i_pkg::item_flags_t      flags,
  m3i_out_if.source                 inv
);
  import m3i_pkg::*;

  localparam int RW = rem_width(W, F);
  localparam logic [W-1:0] HALF = {1'b1, {(W-1){1'b0}}};

  logic                 adv;
  logic [W:0]           vld;
  logic [RW-1:0]        rem  [W][N_ENT];
  logic [W-1:0]         quo  [W+1][N_ENT];
  logic [DEN_W-1:0]     den  [W];
  logic [N_ENT-1:0]     big  [W+1];
  item_flags_t          flg  [W+1];

  logic                 out_vld;
  logic signed [W-1:0]  res [N_ENT];
  logic                 res_ovf;
  logic                 res_sing;
  logic [W-1:0]         res_next [N_ENT];
  logic [N_ENT-1:0]     sat;

  // The divider pipeline moves unless a finished result is still waiting.
  assign adv = !out_vld || inv.ready;
  assign pop = q_valid && adv;

  // Valid bits of the divider stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[W-1:0], q_valid};
    end
  end

  // Stage 0: load the dividend and flag quotients that cannot fit in W bits.
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < N_ENT; l++) begin
        rem[0][l] <= RW'(num[l]);
        quo[0][l] <= '0;
        big[0][l] <= RW'(num[l]) >= (RW'(den2) << W);
      end
      den[0] <= den2;
      flg[0] <= flags;
    end
  end

  // One restoring division step per stage, most significant quotient bit first.
  for (genvar s = 1; s <= W; s++) begin : g_step
    logic [RW-1:0]    sh;
    logic [N_ENT-1:0] ge;

    always_comb begin
      sh = RW'(den[s-1]) << (W - s);
      for (int l = 0; l < N_ENT; l++) begin
        ge[l] = rem[s-1][l] >= sh;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        for (int l = 0; l < N_ENT; l++) begin
          quo[s][l] <= {quo[s-1][l][W-2:0], ge[l]};
        end
        big[s] <= big[s-1];
        flg[s] <= flg[s-1];
      end
    end

    if (s < W) begin : g_carry
      always_ff @(posedge clk) begin
        if (adv) begin
          for (int l = 0; l < N_ENT; l++) begin
            rem[s][l] <= ge[l] ? rem[s-1][l] - sh : rem[s-1][l];
          end
          den[s] <= den[s-1];
        end
      end
    end
  end

  // Saturation, sign and the singular case.
  always_comb begin
    logic [W-1:0] lim;
    logic [W-1:0] mag;
    for (int l = 0; l < N_ENT; l++) begin
      lim    = flg[W].neg[l] ? HALF : HALF - W'(1);
      sat[l] = big[W][l] || (quo[W][l] > lim);
      mag    = sat[l] ? lim : quo[W][l];
      if (flg[W].singular) begin
        res_next[l] = '0;
      end else begin
        res_next[l] = flg[W].neg[l] ? -mag : mag;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (adv) begin
      out_vld <= vld[W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < N_ENT; l++) begin
        res[l] <= $signed(res_next[l]);
      end
      res_sing <= flg[W].singular;
      res_ovf  <= !flg[W].singular && (|sat);
    end
  end

  assign inv.valid    = out_vld;
  assign inv.out_r0c0 = res[0];
  assign inv.out_r0c1 = res[1];
  assign inv.out_r0c2 = res[2];
  assign inv.out_r1c0 = res[3];
  assign inv.out_r1c1 = res[4];
  assign inv.out_r1c2 = res[5];
  assign inv.out_r2c0 = res[6];
  assign inv.out_r2c1 = res[7];
  assign inv.out_r2c2 = res[8];
  assign inv.singular = res_sing;
  assign inv.overflow = res_ovf;

endmodule

[hw/rtl/matrix3x3_inverse.sv]
// 3x3 matrix inverse by adjugate over determinant, signed fixed point.
// Channel mat carries one matrix of nine entries (ENTRY_WIDTH bits, FRAC_BITS
// fraction bits) per transfer; channel inv returns the nine inverse entries in
// the same format with the singular and overflow flags, one transfer per matrix,
// in order. Both use valid/ready; a transfer happens when both are high.
// Each entry is rounded once to nearest, ties away from zero, then saturated.
// A zero determinant gives all-zero entries with singular set.
// Throughput is one matrix per cycle while the receiver keeps inv.ready high.
// The path from input transfer to output valid runs through six front stages
// that form products, adjugate and determinant, the two-entry queue, one
// compare stage, one stage per quotient bit in each of nine divider lanes,
// and the output register.
// When the receiver stalls, the divider pipeline holds, the queue fills, and
// then the front holds and drops mat.ready; no transfer is lost.
// Synchronous reset clears all valid bits and the queue; no output is valid
// in the cycle after reset.
module matrix3x3_inverse #(
  parameter int ENTRY_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic       clk,
  input  logic       rst,
  m3i_in_if.sink     mat,
  m3i_out_if.source  inv
);
  import m3i_pkg::*;

  localparam int NUM_W = num_width(ENTRY_WIDTH, FRAC_BITS);
  localparam int DEN_W = den_width(ENTRY_WIDTH);
  localparam int FLG_W = $bits(item_flags_t);
  localparam int QW    = N_ENT * NUM_W + DEN_W + FLG_W;

  logic              push;
  logic              q_ready;
  logic              q_valid;
  logic              pop;
  logic [NUM_W-1:0]  f_num [N_ENT];
  logic [DEN_W-1:0]  f_den2;
  item_flags_t       f_flags;
  logic [NUM_W-1:0]  b_num [N_ENT];
  logic [QW-1:0]     q_wdata;
  logic [QW-1:0]     q_rdata;

  m3i_front #(
    .W (ENTRY_WIDTH),
    .F (FRAC_BITS)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .mat     (mat),
    .push    (push),
    .q_ready (q_ready),
    .num     (f_num),
    .den2    (f_den2),
    .flags   (f_flags)
  );

  // Pack and unpack the queue word.
  for (genvar k = 0; k < N_ENT; k++) begin : g_pack
    assign q_wdata[k*NUM_W +: NUM_W] = f_num[k];
    assign b_num[k] = q_rdata[k*NUM_W +: NUM_W];
  end
  assign q_wdata[N_ENT*NUM_W +: DEN_W]       = f_den2;
  assign q_wdata[N_ENT*NUM_W + DEN_W +: FLG_W] = f_flags;

  m3i_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .ready (q_ready),
    .wdata (q_wdata),
    .valid (q_valid),
    .pop   (pop),
    .rdata (q_rdata)
  );

  m3i_back #(
    .W (ENTRY_WIDTH),
    .F (FRAC_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .pop     (pop),
    .num     (b_num),
    .den2    (q_rdata[N_ENT*NUM_W +: DEN_W]),
    .flags   (item_flags_t'(q_rdata[N_ENT*NUM_W + DEN_W +: FLG_W])),
    .inv     (inv)
  );

endmodule

[hw/rtl/m3i_checker.sv]
module m3i_checker #(
  parameter int W = 32
) (
  input logic           clk,
  input logic           rst,
  input logic           in_valid,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input logic [9*W-1:0] entries,
  input logic           singular,
  input logic           overflow
);
  localparam logic [W-1:0] MAX_POS = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MIN_NEG = {1'b1, {(W-1){1'b0}}};

  logic       in_xfer;
  logic       out_xfer;
  logic [7:0] pending;
  logic [8:0] hit_lim;

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;

  // Matrices accepted but not yet delivered.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 8'(in_xfer) - 8'(out_xfer);
    end
  end

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      hit_lim[k] = (entries[k*W +: W] == MAX_POS) || (entries[k*W +: W] == MIN_NEG);
    end
  end

  // No result appears without a matrix behind it.
  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pending != 8'd0))
    else $error("result shown with no matrix in flight");

  // A singular result carries only zeros and no overflow.
  a_singular_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && singular) |-> (!overflow && (entries == '0)))
    else $error("singular result with nonzero entries or overflow");

  // Overflow means some entry sits at a range limit.
  a_overflow_limit: assert property (@(posedge clk) disable iff (rst)
    (out_valid && overflow) |-> (hit_lim != 9'd0))
    else $error("overflow flagged but no entry saturated");

  // A stalled result holds.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(entries)
      && $stable(singular) && $stable(overflow)))
    else $error("stalled result changed");

endmodule

bind matrix3x3_inverse m3i_checker #(
  .W (ENTRY_WIDTH)
) u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (mat.valid),
  .in_ready  (mat.ready),
  .out_valid (inv.valid),
  .out_ready (inv.ready),
  .entries   ({inv.out_r2c2, inv.out_r2c1, inv.out_r2c0, inv.out_r1c2, inv.out_r1c1,
               inv.out_r1c0, inv.out_r0c2, inv.out_r0c1, inv.out_r0c0}),
  .singular  (inv.singular),
  .overflow  (inv.overflow)
);

[tb/sv/m3i_inverse_checker.sv]
`timescale 1ns / 1ps

// Watches both channels, predicts each inverse and compares it field by field.
module m3i_inverse_checker (
  input  logic clk,
  input  logic rst,
  m3i_in_if    mat,
  m3i_out_if   inv,
  output int   fail_count,
  output int   inverses_pending
);
  import m3i_pkg::*;

  typedef logic signed [127:0] wide_t;
  typedef logic signed [31:0] entry_arr_t [N_ENT];

  typedef struct {
    logic signed [31:0] ent [N_ENT];
    logic               singular;
    logic               overflow;
  } inverse_t;

  inverse_t inverse_q[$];

  string ent_name [N_ENT] = '{"out_r0c0", "out_r0c1", "out_r0c2", "out_r1c0",
                              "out_r1c1", "out_r1c2", "out_r2c0", "out_r2c1",
                              "out_r2c2"};

  function automatic wide_t mag(wide_t v);
    return (v < 0) ? -v : v;
  endfunction

  // One inverse entry: round(C * 2^32 / D), ties away from zero, saturated.
  function automatic logic signed [31:0] scaled_quotient(wide_t c, wide_t d, ref logic ovf);
    logic  neg;
    wide_t num;
    wide_t q;
    wide_t lim;
    neg = (c < 0) != (d < 0);
    num = (mag(c) <<< 33) + mag(d);
    q = $unsigned(num) / $unsigned(mag(d) <<< 1);
    lim = neg ? (wide_t'(1) <<< 31) : ((wide_t'(1) <<< 31) - 1);
    if (q > lim) begin
      q = lim;
      ovf = 1'b1;
    end
    return neg ? -q[31:0] : q[31:0];
  endfunction

  function automatic inverse_t invert(entry_arr_t m);
    inverse_t r;
    wide_t    w [N_ENT];
    wide_t    adj [N_ENT];
    wide_t    det;
    logic     ovf;
    for (int i = 0; i < N_ENT; i++) w[i] = wide_t'(m[i]);
    adj[0] = w[4] * w[8] - w[5] * w[7];
    adj[1] = w[2] * w[7] - w[1] * w[8];
    adj[2] = w[1] * w[5] - w[2] * w[4];
    adj[3] = w[5] * w[6] - w[3] * w[8];
    adj[4] = w[0] * w[8] - w[2] * w[6];
    adj[5] = w[2] * w[3] - w[0] * w[5];
    adj[6] = w[3] * w[7] - w[4] * w[6];
    adj[7] = w[1] * w[6] - w[0] * w[7];
    adj[8] = w[0] * w[4] - w[1] * w[3];
    det = w[0] * adj[0] + w[1] * adj[3] + w[2] * adj[6];
    ovf = 1'b0;
    if (det == 0) begin
      for (int i = 0; i < N_ENT; i++) r.ent[i] = '0;
      r.singular = 1'b1;
      r.overflow = 1'b0;
    end else begin
      for (int i = 0; i < N_ENT; i++) r.ent[i] = scaled_quotient(adj[i], det, ovf);
      r.singular = 1'b0;
      r.overflow = ovf;
    end
    return r;
  endfunction

  assign inverses_pending = inverse_q.size();

  // Predict on every matrix transfer, compare on every inverse transfer.
  always @(posedge clk) begin
    entry_arr_t m;
    inverse_t   exp_inv;
    logic signed [31:0] got [N_ENT];
    int         errs;
    errs = 0;
    if (!rst && mat.valid && mat.ready) begin
      m = '{mat.in_r0c0, mat.in_r0c1, mat.in_r0c2, mat.in_r1c0, mat.in_r1c1,
            mat.in_r1c2, mat.in_r2c0, mat.in_r2c1, mat.in_r2c2};
      inverse_q.push_back(invert(m));
    end
    if (!rst && inv.valid && inv.ready) begin
      got = '{inv.out_r0c0, inv.out_r0c1, inv.out_r0c2, inv.out_r1c0, inv.out_r1c1,
              inv.out_r1c2, inv.out_r2c0, inv.out_r2c1, inv.out_r2c2};
      if (inverse_q.size() == 0) begin
        $error("inverse transfer with no matrix outstanding");
        errs++;
      end else begin
        exp_inv = inverse_q.pop_front();
        for (int i = 0; i < N_ENT; i++) begin
          if (got[i] !== exp_inv.ent[i]) begin
            $error("%s: expected %0d, actual %0d", ent_name[i], exp_inv.ent[i], got[i]);
            errs++;
          end
        end
        if (inv.singular !== exp_inv.singular) begin
          $error("singular: expected %0b, actual %0b", exp_inv.singular, inv.singular);
          errs++;
        end
        if (inv.overflow !== exp_inv.overflow) begin
          $error("overflow: expected %0b, actual %0b", exp_inv.overflow, inv.overflow);
          errs++;
        end
      end
    end
    // At most one update of the count per clock edge.
    if (errs != 0) begin
      fail_count <= fail_count + errs;
    end
  end

endmodule

[tb/sv/matrix3x3_inverse_tb.sv]
`timescale 1ns / 1ps

module matrix3x3_inverse_tb;
  import m3i_pkg::*;

  localparam int ONE          = 32'h0001_0000;
  localparam int LATENCY      = 41;
  localparam int N_RANDOM     = 1830;
  localparam int QUIET_FROM   = 1600;
  localparam int LONG_HOLD_AT = 519;
  localparam int CYCLE_CAP    = 400000;

  typedef logic signed [31:0] entry_arr_t [N_ENT];

  logic clk;
  logic rst;
  int   fail_count;
  int   inverses_pending;
  int   sent;
  int   cycles;

  m3i_in_if  mat ();
  m3i_out_if inv ();

  matrix3x3_inverse i_dut (
    .clk (clk),
    .rst (rst),
    .mat (mat),
    .inv (inv)
  );

  m3i_inverse_checker i_checker (
    .clk              (clk),
    .rst              (rst),
    .mat              (mat),
    .inv              (inv),
    .fail_count       (fail_count),
    .inverses_pending (inverses_pending)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // Cycle cap guards against a hung handshake.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Receiver: random stall bursts, one long hold-off, no stalls near the end.
  initial begin
    bit long_done;
    long_done = 1'b0;
    inv.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (!long_done && sent >= LONG_HOLD_AT) begin
        inv.ready = 1'b0;
        repeat (300) @(negedge clk);
        long_done = 1'b1;
      end else if (sent < QUIET_FROM && $urandom_range(0, 3) == 0) begin
        inv.ready = 1'b0;
        repeat ($urandom_range(1, 16)) @(negedge clk);
      end else begin
        inv.ready = 1'b1;
        repeat ($urandom_range(1, 16)) @(negedge clk);
      end
    end
  end

  // Offer one matrix; valid stays high until the transfer.
  task automatic offer_matrix(entry_arr_t m);
    mat.valid   = 1'b1;
    mat.in_r0c0 = m[0];
    mat.in_r0c1 = m[1];
    mat.in_r0c2 = m[2];
    mat.in_r1c0 = m[3];
    mat.in_r1c1 = m[4];
    mat.in_r1c2 = m[5];
    mat.in_r2c0 = m[6];
    mat.in_r2c1 = m[7];
    mat.in_r2c2 = m[8];
    @(posedge clk);
    while (!mat.ready) @(posedge clk);
    sent++;
    @(negedge clk);
    if (sent < QUIET_FROM && $urandom_range(0, 4) == 0) begin
      mat.valid = 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
  endtask

  function automatic entry_arr_t diag3(int a, int b, int c);
    return '{a, 0, 0, 0, b, 0, 0, 0, c};
  endfunction

  function automatic logic signed [31:0] rand_entry(int kind);
    case (kind)
      0: return $urandom();
      1: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
      2: return $signed($urandom_range(0, 32'h0000_0400)) - 32'sh0000_0200;
      default: return $signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000;
    endcase
  endfunction

  initial begin
    entry_arr_t m;
    int         kind;
    rst = 1'b1;
    mat.valid = 1'b0;
    mat.in_r0c0 = '0; mat.in_r0c1 = '0; mat.in_r0c2 = '0;
    mat.in_r1c0 = '0; mat.in_r1c1 = '0; mat.in_r1c2 = '0;
    mat.in_r2c0 = '0; mat.in_r2c1 = '0; mat.in_r2c2 = '0;
    sent = 0;
    repeat (5) @(negedge clk);
    rst = 1'b0;

    // Directed: identity, zero determinant, field extremes, saturation.
    offer_matrix(diag3(ONE, ONE, ONE));
    offer_matrix('{0, 0, 0, 0, 0, 0, 0, 0, 0});
    offer_matrix(diag3(2 * ONE, -4 * ONE, ONE / 2));
    offer_matrix(diag3(1, 1, 1));
    offer_matrix(diag3(-1, 1, 1));
    offer_matrix(diag3(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff));
    offer_matrix(diag3(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000));
    offer_matrix(diag3(32'sh8000_0000, 32'sh7fff_ffff, 1));
    offer_matrix('{32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
                   32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
                   32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff});
    offer_matrix('{32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000,
                   32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff,
                   32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff});
    offer_matrix('{0, ONE, 0, 0, 0, ONE, ONE, 0, 0});
    offer_matrix('{ONE, 2 * ONE, 3 * ONE, 4 * ONE, 5 * ONE, 6 * ONE,
                   7 * ONE, 8 * ONE, 9 * ONE});
    offer_matrix('{2 * ONE, ONE, 0, ONE, 2 * ONE, ONE, 0, ONE, 2 * ONE});
    offer_matrix('{3 * ONE, 0, 0, 0, 3 * ONE, 0, 0, 0, 3 * ONE});
    offer_matrix('{-1, -1, -1, -1, -1, -1, -1, -1, -1});
    offer_matrix('{ONE, 0, 0, 0, ONE, 0, 0, 0, 0});
    offer_matrix(diag3(1, 2, 3));
    offer_matrix('{ONE, ONE / 2, 0, -ONE / 2, ONE, 0, 3, -5, ONE});
    offer_matrix(diag3(ONE * 16384, ONE * 16384, ONE * 16384));

    // Sender pause: let every outstanding inverse arrive.
    mat.valid = 1'b0;
    while (inverses_pending != 0) @(negedge clk);

    // Random matrices, some of them rank deficient.
    for (int n = 0; n < N_RANDOM; n++) begin
      kind = $urandom_range(0, 3);
      for (int i = 0; i < N_ENT; i++) m[i] = rand_entry(kind);
      case ($urandom_range(0, 7))
        0: for (int i = 0; i < 3; i++) m[6 + i] = m[i];
        1: for (int i = 0; i < 3; i++) m[3 * i + 2] = -m[3 * i + 1];
        2: begin
          m[1] = 0; m[2] = 0; m[3] = 0; m[5] = 0; m[6] = 0; m[7] = 0;
        end
        default: ;
      endcase
      offer_matrix(m);
    end
    mat.valid = 1'b0;

    while (inverses_pending != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
